FILE: hdl/pt3d_pkg.sv
// shared types and constants for the 3d point transform
`timescale 1ns / 1ps
package pt3d_pkg;

	localparam int DEF_COORD_BITS      = 12;
	localparam int DEF_SCALE_FRAC_BITS = 8;
	localparam int DEF_TRIG_FRAC_BITS  = 14;

	localparam int SCALE_INT_BITS = 4;
	localparam int ANGLE_BITS     = 9;
	localparam int MODE_BITS      = 3;
	localparam int CFG_INDEX_BITS = 3;

	localparam int ANGLE_RANGE = 360;
	localparam int QUARTER     = 90;
	localparam int HALF_TURN   = 180;
	localparam int THREE_QTR   = 270;

	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_SCALE     = 3'd1,
		MODE_ROT_X     = 3'd2,
		MODE_ROT_Y     = 3'd3,
		MODE_ROT_Z     = 3'd4
	} mode_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MODE    = 3'd0,
		REG_SHIFT_X = 3'd1,
		REG_SHIFT_Y = 3'd2,
		REG_SHIFT_Z = 3'd3,
		REG_SCALE_X = 3'd4,
		REG_SCALE_Y = 3'd5,
		REG_SCALE_Z = 3'd6,
		REG_ANGLE   = 3'd7
	} cfg_reg_t;

	// widest register decides the config data width
	function automatic int cfg_data_bits(input int coord_bits, input int scale_frac_bits);
		int w;
		w = coord_bits;
		if (scale_frac_bits + SCALE_INT_BITS > w) begin
			w = scale_frac_bits + SCALE_INT_BITS;
		end
		if (ANGLE_BITS > w) begin
			w = ANGLE_BITS;
		end
		return w;
	endfunction

endpackage

FILE: hdl/pt3d_point_if.sv
// point channel: valid/ready plus the three input coordinates
`timescale 1ns / 1ps
interface pt3d_point_if #(
	parameter int COORD_BITS = pt3d_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic signed [COORD_BITS-1:0] in_z;

	modport source (output valid, output in_x, output in_y, output in_z, input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

FILE: hdl/pt3d_result_if.sv
// result channel: valid/ready plus transformed coordinates and clip flag
`timescale 1ns / 1ps
interface pt3d_result_if #(
	parameter int COORD_BITS = pt3d_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic                         clipped;

	modport source (output valid, output out_x, output out_y, output out_z, output clipped,
		input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input clipped,
		output ready);
endinterface

FILE: hdl/pt3d_cfg_if.sv
// configuration write channel: register index and write data
`timescale 1ns / 1ps
interface pt3d_cfg_if #(
	parameter int DATA_BITS = pt3d_pkg::DEF_COORD_BITS
);
	logic                                    valid;
	logic                                    ready;
	logic [pt3d_pkg::CFG_INDEX_BITS-1:0]     index;
	logic [DATA_BITS-1:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/point_transform_3d.sv
// 3d affine point transform: translate, scale or rotate about one axis
`timescale 1ns / 1ps
// a point is held in the input register, then in the result register
// (one combinational pass between them)
// throughput: one point per cycle; input ready drops only while both the input register
// and the result register are full and the sink is stalled
// reset clears both pipeline valids and sets the config to identity (translate by zero,
// unit scale, zero angle); an angle write loads sine and cosine directly from a 91-entry table
module point_transform_3d #(
	parameter int COORD_BITS      = pt3d_pkg::DEF_COORD_BITS,
	parameter int SCALE_FRAC_BITS = pt3d_pkg::DEF_SCALE_FRAC_BITS,
	parameter int TRIG_FRAC_BITS  = pt3d_pkg::DEF_TRIG_FRAC_BITS
) (
	input logic            clk,
	input logic            arst_n,
	pt3d_cfg_if.sink       cfg,
	pt3d_point_if.sink     point_in,
	pt3d_result_if.source  point_out
);
	import pt3d_pkg::*;

	localparam int SCALE_BITS  = SCALE_FRAC_BITS + SCALE_INT_BITS;
	localparam int TRIG_W      = TRIG_FRAC_BITS + 2;
	localparam int ROT_ACC_W   = COORD_BITS + TRIG_FRAC_BITS + 4;
	localparam int SCL_ACC_W   = COORD_BITS + SCALE_BITS + 2;
	localparam int ACC_W       = (ROT_ACC_W > SCL_ACC_W) ? ROT_ACC_W : SCL_ACC_W;
	localparam int QTR_ENTRIES = QUARTER + 1;
	localparam int IDX_W       = $clog2(QTR_ENTRIES);
	localparam int AXES        = 3;

	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (COORD_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [COORD_BITS-1:0]   OUT_MAX = SAT_HI[COORD_BITS-1:0];
	localparam logic [COORD_BITS-1:0]   OUT_MIN = SAT_LO[COORD_BITS-1:0];
	localparam logic [ANGLE_BITS-1:0]   A_RANGE = ANGLE_BITS'(ANGLE_RANGE);
	localparam logic [ANGLE_BITS-1:0]   A_QTR   = ANGLE_BITS'(QUARTER);
	localparam logic [ANGLE_BITS-1:0]   A_HALF  = ANGLE_BITS'(HALF_TURN);
	localparam logic [ANGLE_BITS-1:0]   A_3QTR  = ANGLE_BITS'(THREE_QTR);

	// quarter-wave sine table, unsigned with TRIG_FRAC_BITS fraction bits
	logic [TRIG_FRAC_BITS:0] sin_tab [QTR_ENTRIES];

	for (genvar gi = 0; gi < QTR_ENTRIES; gi++) begin : g_sin
		// angle in radians, q30, then the taylor terms x^(2k+1)/(2k+1)!
		localparam logic [63:0] X   = (64'(gi) * PI_Q30 + 64'(QUARTER)) / 64'(HALF_TURN);
		localparam logic [63:0] X2  = (X * X) >> 30;
		localparam logic [63:0] T1  = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
		localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
		localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd272;
		localparam logic [63:0] T9  = ((T8 * X2) >> 30) / 64'd342;
		localparam logic [63:0] T10 = ((T9 * X2) >> 30) / 64'd420;
		localparam logic [63:0] T11 = ((T10 * X2) >> 30) / 64'd506;
		localparam logic [63:0] T12 = ((T11 * X2) >> 30) / 64'd600;
		localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10
			- T11 + T12;
		localparam logic [63:0] RAW = (SUM > ONE_Q30) ? ONE_Q30 : SUM;
		localparam logic [63:0] QV  = (RAW + (64'd1 << (29 - TRIG_FRAC_BITS)))
			>> (30 - TRIG_FRAC_BITS);
		assign sin_tab[gi] = QV[TRIG_FRAC_BITS:0];
	end

	// fold an angle in 0..359 into the first quadrant: {negate, table index}
	function automatic logic [IDX_W:0] fold(input logic [ANGLE_BITS-1:0] a);
		logic [ANGLE_BITS-1:0] d;
		logic                  neg;
		neg = 1'b0;
		priority if (a <= A_QTR) begin
			d = a;
		end else if (a <= A_HALF) begin
			d = A_HALF - a;
		end else if (a <= A_3QTR) begin
			d   = a - A_HALF;
			neg = 1'b1;
		end else begin
			d   = A_RANGE - a;
			neg = 1'b1;
		end
		return {neg, d[IDX_W-1:0]};
	endfunction

	// add one half lsb, then drop f bits toward zero
	function automatic logic signed [ACC_W-1:0] round_shift(
		input logic signed [ACC_W-1:0] v,
		input int unsigned             f
	);
		logic signed [ACC_W-1:0] n;
		logic signed [ACC_W-1:0] q;
		logic [ACC_W-1:0]        mask;
		n    = v + $signed(ACC_W'(1) << (f - 1));
		mask = (ACC_W'(1) << f) - ACC_W'(1);
		q    = n >>> f;
		if (n[ACC_W-1] && ((n & mask) != '0)) begin
			q = q + $signed(ACC_W'(1));
		end
		return q;
	endfunction

	// {clip, saturated coordinate}
	function automatic logic [COORD_BITS:0] saturate(input logic signed [ACC_W-1:0] v);
		logic [COORD_BITS:0] r;
		priority if (v > SAT_HI) begin
			r = {1'b1, OUT_MAX};
		end else if (v < SAT_LO) begin
			r = {1'b1, OUT_MIN};
		end else begin
			r = {1'b0, v[COORD_BITS-1:0]};
		end
		return r;
	endfunction

	// ---------------- configuration ----------------

	logic                          cfg_we;
	logic [ANGLE_BITS-1:0]         ang_raw;
	logic [ANGLE_BITS-1:0]         ang_mod;
	logic [ANGLE_BITS-1:0]         ang_cos_sum;
	logic [ANGLE_BITS-1:0]         ang_cos;
	logic [IDX_W:0]                sin_fold;
	logic [IDX_W:0]                cos_fold;
	logic signed [TRIG_W-1:0]      sin_mag;
	logic signed [TRIG_W-1:0]      cos_mag;
	logic signed [TRIG_W-1:0]      sin_val;
	logic signed [TRIG_W-1:0]      cos_val;

	mode_t                         mode_q;
	logic signed [COORD_BITS-1:0]  shift_q [AXES];
	logic signed [SCALE_BITS-1:0]  scale_q [AXES];
	logic signed [TRIG_W-1:0]      sin_q;
	logic signed [TRIG_W-1:0]      cos_q;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	always_comb begin
		ang_raw     = cfg.data[ANGLE_BITS-1:0];
		ang_mod     = (ang_raw >= A_RANGE) ? ang_raw - A_RANGE : ang_raw;
		ang_cos_sum = ang_mod + A_QTR;
		ang_cos     = (ang_cos_sum >= A_RANGE) ? ang_cos_sum - A_RANGE : ang_cos_sum;
		sin_fold    = fold(ang_mod);
		cos_fold    = fold(ang_cos);
		sin_mag     = $signed({1'b0, sin_tab[sin_fold[IDX_W-1:0]]});
		cos_mag     = $signed({1'b0, sin_tab[cos_fold[IDX_W-1:0]]});
		sin_val     = sin_fold[IDX_W] ? -sin_mag : sin_mag;
		cos_val     = cos_fold[IDX_W] ? -cos_mag : cos_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TRANSLATE;
			for (int i = 0; i < AXES; i++) begin
				shift_q[i] <= '0;
				scale_q[i] <= SCALE_BITS'(1) << SCALE_FRAC_BITS;
			end
			sin_q <= '0;
			cos_q <= TRIG_W'(1) << TRIG_FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MODE:    mode_q     <= mode_t'(cfg.data[MODE_BITS-1:0]);
				REG_SHIFT_X: shift_q[0] <= cfg.data[COORD_BITS-1:0];
				REG_SHIFT_Y: shift_q[1] <= cfg.data[COORD_BITS-1:0];
				REG_SHIFT_Z: shift_q[2] <= cfg.data[COORD_BITS-1:0];
				REG_SCALE_X: scale_q[0] <= cfg.data[SCALE_BITS-1:0];
				REG_SCALE_Y: scale_q[1] <= cfg.data[SCALE_BITS-1:0];
				REG_SCALE_Z: scale_q[2] <= cfg.data[SCALE_BITS-1:0];
				REG_ANGLE: begin
					sin_q <= sin_val;
					cos_q <= cos_val;
				end
				default: ;
			endcase
		end
	end

	// ---------------- pipeline ----------------

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          adv_s1;
	logic                          adv_s2;
	logic signed [COORD_BITS-1:0]  pt_s1 [AXES];
	logic signed [COORD_BITS-1:0]  res_s2 [AXES];
	logic                          clip_s2;

	assign adv_s2         = !valid_s2 || point_out.ready;
	assign adv_s1         = !valid_s1 || adv_s2;
	assign point_in.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= point_in.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (point_in.valid && adv_s1) begin
			pt_s1[0] <= point_in.in_x;
			pt_s1[1] <= point_in.in_y;
			pt_s1[2] <= point_in.in_z;
		end
	end

	// ---------------- transform ----------------

	logic signed [ACC_W-1:0]  p [AXES];
	logic signed [ACC_W-1:0]  pc [AXES];
	logic signed [ACC_W-1:0]  ps [AXES];
	logic signed [ACC_W-1:0]  scl [AXES];
	logic signed [ACC_W-1:0]  res [AXES];
	logic [COORD_BITS:0]      sat [AXES];
	logic                     clip_any;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			p[i]   = ACC_W'(pt_s1[i]);
			pc[i]  = p[i] * ACC_W'(cos_q);
			ps[i]  = p[i] * ACC_W'(sin_q);
			scl[i] = round_shift(p[i] * ACC_W'(scale_q[i]), SCALE_FRAC_BITS);
			res[i] = p[i];
		end
		unique case (mode_q)
			MODE_TRANSLATE: begin
				for (int i = 0; i < AXES; i++) begin
					res[i] = p[i] + ACC_W'(shift_q[i]);
				end
			end
			MODE_SCALE: begin
				for (int i = 0; i < AXES; i++) begin
					res[i] = scl[i];
				end
			end
			MODE_ROT_X: begin
				res[1] = round_shift(pc[1] - ps[2], TRIG_FRAC_BITS);
				res[2] = round_shift(ps[1] + pc[2], TRIG_FRAC_BITS);
			end
			MODE_ROT_Y: begin
				res[0] = round_shift(pc[0] - ps[2], TRIG_FRAC_BITS);
				res[2] = round_shift(ps[0] + pc[2], TRIG_FRAC_BITS);
			end
			MODE_ROT_Z: begin
				res[0] = round_shift(pc[0] + ps[1], TRIG_FRAC_BITS);
				res[1] = round_shift(pc[1] - ps[0], TRIG_FRAC_BITS);
			end
			// unused mode codes pass the point through
			default: ;
		endcase
		clip_any = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			sat[i]   = saturate(res[i]);
			clip_any = clip_any | sat[i][COORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			for (int i = 0; i < AXES; i++) begin
				res_s2[i] <= sat[i][COORD_BITS-1:0];
			end
			clip_s2 <= clip_any;
		end
	end

	assign point_out.valid   = valid_s2;
	assign point_out.out_x   = res_s2[0];
	assign point_out.out_y   = res_s2[1];
	assign point_out.out_z   = res_s2[2];
	assign point_out.clipped = clip_s2;

	// ---------------- checks ----------------

	a_clip_on_rail: assert property (@(posedge clk) disable iff (!arst_n)
		point_out.valid && point_out.clipped |->
			point_out.out_x == OUT_MAX || point_out.out_x == OUT_MIN ||
			point_out.out_y == OUT_MAX || point_out.out_y == OUT_MIN ||
			point_out.out_z == OUT_MAX || point_out.out_z == OUT_MIN)
		else $error("clip flag set with no coordinate on a rail");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!point_out.valid || point_out.ready) |-> point_in.ready)
		else $error("input stalled while result register can drain");

	a_zero_angle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == REG_ANGLE &&
			cfg.data[ANGLE_BITS-1:0] == '0 |=>
			cos_q == (TRIG_W'(1) << TRIG_FRAC_BITS) && sin_q == '0)
		else $error("zero angle did not load unit cosine");

	a_trig_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cos_q != '0 || sin_q != '0)
		else $error("sine and cosine both zero");

endmodule
